FILE: rtl/core/dlac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the door lock access controller.
// No dependencies; every module of the block imports this package.
package dlac_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int ADC_BITS_DEF   = 12;

  localparam int TIME_W  = 16;
  localparam int UID_W   = 32;
  localparam int ANGLE_W = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Full-scale tilt angle for a sample at the converter maximum.
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = 9'd342;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_GAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTUATE_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_UID    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH    = 3'd6;

  // Register values after reset.
  localparam logic [TIME_W-1:0]  OPEN_TIME_RST    = 16'd15000;
  localparam logic [TIME_W-1:0]  CARD_GAP_RST     = 16'd5000;
  localparam logic [TIME_W-1:0]  WARN_DELAY_RST   = 16'd10000;
  localparam logic [TIME_W-1:0]  ACTUATE_TIME_RST = 16'd2000;
  localparam logic [UID_W-1:0]   VALID_UID_RST    = 32'h61C5_7A10;
  localparam logic [ANGLE_W-1:0] TILT_LOW_RST     = 9'd30;
  localparam logic [ANGLE_W-1:0] TILT_HIGH_RST    = 9'd120;

  typedef enum logic [1:0] {
    SND_NONE  = 2'd0,
    SND_GRANT = 2'd1,
    SND_DENY  = 2'd2,
    SND_WARN  = 2'd3
  } sound_t;

  typedef struct packed {
    logic [TIME_W-1:0]  open_time_ms;
    logic [TIME_W-1:0]  card_gap_ms;
    logic [TIME_W-1:0]  warning_delay_ms;
    logic [TIME_W-1:0]  actuate_time_ms;
    logic [UID_W-1:0]   valid_card_uid;
    logic [ANGLE_W-1:0] tilt_low_angle;
    logic [ANGLE_W-1:0] tilt_high_angle;
  } cfg_t;

  // One tick as the decision logic sees it, knob tests already made.
  typedef struct packed {
    logic              override_request;
    logic              card_present;
    logic [UID_W-1:0]  card_uid;
    logic              door_switch_open;
    logic              inside_turned;
    logic              outside_turned;
  } evt_t;

  typedef struct packed {
    logic   solenoid_drive;
    logic   door_unlocked;
    sound_t sound_event;
    logic   actuation_changed;
  } res_t;

endpackage

FILE: rtl/core/dlac_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the door lock controller.
// Depends on dlac_pkg for the register indexes, reset values and cfg_t.
module dlac_cfg_regs
  import dlac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_OPEN_TIME:    cfg_nxt.open_time_ms     = cfg_wdata[TIME_W-1:0];
        REG_CARD_GAP:     cfg_nxt.card_gap_ms      = cfg_wdata[TIME_W-1:0];
        REG_WARN_DELAY:   cfg_nxt.warning_delay_ms = cfg_wdata[TIME_W-1:0];
        REG_ACTUATE_TIME: cfg_nxt.actuate_time_ms  = cfg_wdata[TIME_W-1:0];
        REG_VALID_UID:    cfg_nxt.valid_card_uid   = cfg_wdata[UID_W-1:0];
        REG_TILT_LOW:     cfg_nxt.tilt_low_angle   = cfg_wdata[ANGLE_W-1:0];
        REG_TILT_HIGH:    cfg_nxt.tilt_high_angle  = cfg_wdata[ANGLE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_time_ms     <= OPEN_TIME_RST;
      cfg_r.card_gap_ms      <= CARD_GAP_RST;
      cfg_r.warning_delay_ms <= WARN_DELAY_RST;
      cfg_r.actuate_time_ms  <= ACTUATE_TIME_RST;
      cfg_r.valid_card_uid   <= VALID_UID_RST;
      cfg_r.tilt_low_angle   <= TILT_LOW_RST;
      cfg_r.tilt_high_angle  <= TILT_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/dlac_tilt.sv
`timescale 1ns / 1ps
// Tilt knob test: scales a raw converter sample to an angle and checks the window.
// Depends on dlac_pkg for ANGLE_W and ANGLE_FULL.
module dlac_tilt
  import dlac_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic [ADC_BITS-1:0] sample,
  input  logic [ANGLE_W-1:0]  low_angle,
  input  logic [ANGLE_W-1:0]  high_angle,
  output logic                turned
);

  localparam int PROD_W = ADC_BITS + ANGLE_W;
  localparam int SUM_W  = ADC_BITS + 2;
  localparam logic [SUM_W-1:0] ADC_MAX = {2'b00, {ADC_BITS{1'b1}}};

  logic [PROD_W-1:0]  prod;
  logic [ANGLE_W-1:0] quo_hi;
  logic [SUM_W-1:0]   fold;
  logic [SUM_W-1:0]   fold_sub;
  logic               corr0;
  logic               corr1;
  logic [ANGLE_W-1:0] angle;

  // Division by 2^N-1: x = q*2^N + l = q*(2^N-1) + (q+l), and q+l stays
  // below three times the divisor, so two compare-and-subtract steps finish it.
  always_comb begin
    prod     = PROD_W'(sample) * PROD_W'(ANGLE_FULL);
    quo_hi   = prod[PROD_W-1:ADC_BITS];
    fold     = SUM_W'(quo_hi) + SUM_W'(prod[ADC_BITS-1:0]);
    corr0    = (fold >= ADC_MAX);
    fold_sub = corr0 ? (fold - ADC_MAX) : fold;
    corr1    = (fold_sub >= ADC_MAX);
    angle    = quo_hi + ANGLE_W'(corr0) + ANGLE_W'(corr1);
    turned   = (angle >= low_angle) && (angle <= high_angle);
  end

endmodule

FILE: rtl/core/dlac_ctrl.sv
`timescale 1ns / 1ps
// Lock state, elapsed-time counters and the per-tick priority decision.
// Depends on dlac_pkg for cfg_t, evt_t, res_t and the sound codes.
module dlac_ctrl
  import dlac_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  cfg_t cfg,
  input  evt_t evt,
  output res_t res
);

  localparam int CMP_W = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;

  typedef logic [TIMER_BITS-1:0] cnt_t;

  logic door_r, door_nxt;
  logic act_r, act_nxt;
  logic sol_r, sol_nxt;
  cnt_t since_open_r, since_open_nxt;
  cnt_t since_scan_r, since_scan_nxt;
  cnt_t since_warn_r, since_warn_nxt;
  cnt_t since_act_r, since_act_nxt;
  sound_t snd;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic past(input cnt_t c, input logic [TIME_W-1:0] t);
    return CMP_W'(c) > CMP_W'(t);
  endfunction

  always_comb begin
    since_open_nxt = sat_inc(since_open_r);
    since_scan_nxt = sat_inc(since_scan_r);
    since_warn_nxt = sat_inc(since_warn_r);
    since_act_nxt  = sat_inc(since_act_r);
    door_nxt = door_r;
    act_nxt  = act_r;
    sol_nxt  = sol_r;
    snd      = SND_NONE;

    // The solenoid pulse ends before any action of this tick is chosen.
    if (act_r && past(since_act_nxt, cfg.actuate_time_ms)) begin
      since_act_nxt = '0;
      sol_nxt       = 1'b0;
      act_nxt       = 1'b0;
    end

    if (evt.override_request && !door_r) begin
      snd            = SND_GRANT;
      sol_nxt        = 1'b0;
      act_nxt        = 1'b0;
      door_nxt       = 1'b1;
      since_open_nxt = '0;
    end else if (evt.card_present && past(since_scan_nxt, cfg.card_gap_ms) && !door_r) begin
      since_scan_nxt = '0;
      if (evt.card_uid == cfg.valid_card_uid) begin
        snd            = SND_GRANT;
        sol_nxt        = 1'b0;
        act_nxt        = 1'b0;
        door_nxt       = 1'b1;
        since_open_nxt = '0;
      end else begin
        snd = SND_DENY;
      end
    end else if (door_r && past(since_open_nxt, cfg.open_time_ms)) begin
      if (!evt.door_switch_open) begin
        sol_nxt       = 1'b1;
        door_nxt      = 1'b0;
        act_nxt       = 1'b1;
        since_act_nxt = '0;
      end else if (past(since_warn_nxt, cfg.warning_delay_ms)) begin
        snd            = SND_WARN;
        since_warn_nxt = '0;
      end
    end else if (!door_r && evt.inside_turned) begin
      sol_nxt       = 1'b1;
      door_nxt      = 1'b0;
      act_nxt       = 1'b1;
      since_act_nxt = '0;
      snd           = SND_WARN;
    end else if (!door_r && evt.outside_turned) begin
      snd            = SND_GRANT;
      sol_nxt        = 1'b0;
      act_nxt        = 1'b0;
      door_nxt       = 1'b1;
      since_open_nxt = '0;
    end

    res.solenoid_drive    = sol_nxt;
    res.door_unlocked     = door_nxt;
    res.sound_event       = snd;
    res.actuation_changed = (act_nxt != act_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_r       <= 1'b0;
      act_r        <= 1'b0;
      sol_r        <= 1'b0;
      since_open_r <= '0;
      since_scan_r <= '0;
      since_warn_r <= '0;
      since_act_r  <= '0;
    end else if (en) begin
      door_r       <= door_nxt;
      act_r        <= act_nxt;
      sol_r        <= sol_nxt;
      since_open_r <= since_open_nxt;
      since_scan_r <= since_scan_nxt;
      since_warn_r <= since_warn_nxt;
      since_act_r  <= since_act_nxt;
    end
  end

endmodule

FILE: rtl/core/door_lock_access_controller_top.sv
`timescale 1ns / 1ps
// Door lock access controller: one item per millisecond tick in, one result out.
// Usage: each input item carries override, card event, door switch and two tilt
// samples; each output item gives solenoid level, door state, sound event and
// whether the actuated flag changed during that tick.
// Both channels use valid/ready. An accepted item lands in an input register;
// once the result register is free or being read, the decision runs against
// the lock state and loads the result register.
// Throughput is one item per cycle while the receiver keeps up, limited by the
// state update between the input register and the result register.
// A stalled receiver holds the result register; the input register still takes
// one more item, after which in_ready drops until the result is taken.
// Configuration writes take effect at the next edge; write only while idle.
// Reset (synchronous, active low) clears the lock state, all four elapsed-time
// counters and both valid flags, and loads the register defaults.
// Depends on dlac_pkg, dlac_cfg_regs, dlac_tilt and dlac_ctrl.
module door_lock_access_controller_top
  import dlac_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int ADC_BITS   = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_override_request,
  input  logic                  in_card_present,
  input  logic [UID_W-1:0]      in_card_uid,
  input  logic                  in_door_switch_open,
  input  logic [ADC_BITS-1:0]   in_tilt_inside_sample,
  input  logic [ADC_BITS-1:0]   in_tilt_outside_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_solenoid_drive,
  output logic                  out_door_unlocked,
  output logic [1:0]            out_sound_event,
  output logic                  out_actuation_changed
);

  cfg_t cfg;

  logic                s1_valid_r;
  logic                s1_override_r;
  logic                s1_card_r;
  logic [UID_W-1:0]    s1_uid_r;
  logic                s1_switch_r;
  logic [ADC_BITS-1:0] s1_tilt_in_r;
  logic [ADC_BITS-1:0] s1_tilt_out_r;
  logic                s1_adv;
  logic                in_take;

  logic inside_turned;
  logic outside_turned;
  evt_t evt;
  res_t res;

  logic out_valid_r;
  res_t out_res_r;

  dlac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dlac_tilt #(.ADC_BITS(ADC_BITS)) u_tilt_in (
    .sample     (s1_tilt_in_r),
    .low_angle  (cfg.tilt_low_angle),
    .high_angle (cfg.tilt_high_angle),
    .turned     (inside_turned)
  );

  dlac_tilt #(.ADC_BITS(ADC_BITS)) u_tilt_out (
    .sample     (s1_tilt_out_r),
    .low_angle  (cfg.tilt_low_angle),
    .high_angle (cfg.tilt_high_angle),
    .turned     (outside_turned)
  );

  assign evt.override_request = s1_override_r;
  assign evt.card_present     = s1_card_r;
  assign evt.card_uid         = s1_uid_r;
  assign evt.door_switch_open = s1_switch_r;
  assign evt.inside_turned    = inside_turned;
  assign evt.outside_turned   = outside_turned;

  // The held item advances whenever the result register is free or being read.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  dlac_ctrl #(.TIMER_BITS(TIMER_BITS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .cfg   (cfg),
    .evt   (evt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_override_r <= in_override_request;
      s1_card_r     <= in_card_present;
      s1_uid_r      <= in_card_uid;
      s1_switch_r   <= in_door_switch_open;
      s1_tilt_in_r  <= in_tilt_inside_sample;
      s1_tilt_out_r <= in_tilt_outside_sample;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_solenoid_drive    = out_res_r.solenoid_drive;
  assign out_door_unlocked     = out_res_r.door_unlocked;
  assign out_sound_event       = out_res_r.sound_event;
  assign out_actuation_changed = out_res_r.actuation_changed;

  // A decided item always shows up in the result register.
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("decided item did not reach the result register");

  // The solenoid is only driven while the door is locked.
  a_sol_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.solenoid_drive) |-> !out_res_r.door_unlocked)
    else $error("solenoid driven with door unlocked");

  // A grant always leaves the door open, a denial leaves it closed.
  a_grant_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.sound_event == SND_GRANT) |-> out_res_r.door_unlocked)
    else $error("grant without unlocked door");

  a_deny_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.sound_event == SND_DENY) |-> !out_res_r.door_unlocked)
    else $error("deny with unlocked door");

endmodule

FILE: bench/tb_door_lock_access_controller_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for door_lock_access_controller_top: directed ticks, random ticks
// under changing register settings and stall patterns, and thresholds at the counter limit.
// Depends on dlac_pkg and the RTL of the block; the lock predictor lives in the class below.
module tb_door_lock_access_controller_top;
  import dlac_pkg::*;

  localparam int ADC_FULL     = (1 << ADC_BITS_DEF) - 1;
  localparam int WATCH_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASES       = 13;
  localparam int PHASE_TICKS  = 100;

  typedef struct packed {
    logic                    override_request;
    logic                    card_present;
    logic [UID_W-1:0]        card_uid;
    logic                    door_switch_open;
    logic [ADC_BITS_DEF-1:0] tilt_inside;
    logic [ADC_BITS_DEF-1:0] tilt_outside;
  } tick_t;

  // Predicts the lock state per tick and holds the outcomes still to arrive.
  class lock_scoreboard;
    logic [TIME_W-1:0]  open_time, card_gap, warn_delay, actuate_time;
    logic [UID_W-1:0]   uid_accepted;
    logic [ANGLE_W-1:0] tilt_low, tilt_high;
    bit                 door_open, actuated, solenoid;
    logic [TIME_W-1:0]  since_opened, since_scan, since_warning, since_actuated;
    res_t               expected_outcomes[$];
    int                 errors, ticks, grants, denials, warnings, actuations;

    function new();
      open_time      = OPEN_TIME_RST;
      card_gap       = CARD_GAP_RST;
      warn_delay     = WARN_DELAY_RST;
      actuate_time   = ACTUATE_TIME_RST;
      uid_accepted   = VALID_UID_RST;
      tilt_low       = TILT_LOW_RST;
      tilt_high      = TILT_HIGH_RST;
      door_open      = 1'b0;
      actuated       = 1'b0;
      solenoid       = 1'b0;
      since_opened   = '0;
      since_scan     = '0;
      since_warning  = '0;
      since_actuated = '0;
      errors = 0; ticks = 0; grants = 0; denials = 0; warnings = 0; actuations = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OPEN_TIME:    open_time    = data[TIME_W-1:0];
        REG_CARD_GAP:     card_gap     = data[TIME_W-1:0];
        REG_WARN_DELAY:   warn_delay   = data[TIME_W-1:0];
        REG_ACTUATE_TIME: actuate_time = data[TIME_W-1:0];
        REG_VALID_UID:    uid_accepted = data[UID_W-1:0];
        REG_TILT_LOW:     tilt_low     = data[ANGLE_W-1:0];
        REG_TILT_HIGH:    tilt_high    = data[ANGLE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] saturate_up(logic [TIME_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function bit knob_turned(logic [ADC_BITS_DEF-1:0] sample);
      int angle;
      angle = (int'(sample) * int'(ANGLE_FULL)) / ADC_FULL;
      return angle >= int'(tilt_low) && angle <= int'(tilt_high);
    endfunction

    function void open_door();
      solenoid     = 1'b0;
      actuated     = 1'b0;
      door_open    = 1'b1;
      since_opened = '0;
    endfunction

    function void engage_lock();
      solenoid       = 1'b1;
      door_open      = 1'b0;
      actuated       = 1'b1;
      since_actuated = '0;
    endfunction

    function void predict_tick(tick_t t);
      bit     was_actuated;
      sound_t sound;
      res_t   want;
      sound          = SND_NONE;
      since_opened   = saturate_up(since_opened);
      since_scan     = saturate_up(since_scan);
      since_warning  = saturate_up(since_warning);
      since_actuated = saturate_up(since_actuated);
      was_actuated   = actuated;

      if (actuated && since_actuated > actuate_time) begin
        since_actuated = '0;
        solenoid       = 1'b0;
        actuated       = 1'b0;
      end

      // At most one action per tick, highest priority first.
      if (t.override_request && !door_open) begin
        sound = SND_GRANT;
        open_door();
      end else if (t.card_present && since_scan > card_gap && !door_open) begin
        since_scan = '0;
        if (t.card_uid == uid_accepted) begin
          sound = SND_GRANT;
          open_door();
        end else begin
          sound = SND_DENY;
        end
      end else if (door_open && since_opened > open_time) begin
        if (!t.door_switch_open) begin
          engage_lock();
        end else if (since_warning > warn_delay) begin
          sound         = SND_WARN;
          since_warning = '0;
        end
      end else if (!door_open && knob_turned(t.tilt_inside)) begin
        engage_lock();
        sound = SND_WARN;
      end else if (!door_open && knob_turned(t.tilt_outside)) begin
        open_door();
        sound = SND_GRANT;
      end

      want.solenoid_drive    = solenoid;
      want.door_unlocked     = door_open;
      want.sound_event       = sound;
      want.actuation_changed = (actuated != was_actuated);
      ticks++;
      case (sound)
        SND_GRANT: grants++;
        SND_DENY:  denials++;
        SND_WARN:  warnings++;
        default: ;
      endcase
      if (want.actuation_changed) actuations++;
      expected_outcomes.push_back(want);
    endfunction

    function void check_outcome(res_t got);
      res_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result with no tick waiting: solenoid %0b door %0b sound %0d changed %0b",
               got.solenoid_drive, got.door_unlocked, got.sound_event,
               got.actuation_changed);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.solenoid_drive !== want.solenoid_drive) begin
        $error("solenoid_drive: expected %0b, got %0b", want.solenoid_drive,
               got.solenoid_drive);
        errors++;
      end
      if (got.door_unlocked !== want.door_unlocked) begin
        $error("door_unlocked: expected %0b, got %0b", want.door_unlocked,
               got.door_unlocked);
        errors++;
      end
      if (got.sound_event !== want.sound_event) begin
        $error("sound_event: expected %0d, got %0d", want.sound_event, got.sound_event);
        errors++;
      end
      if (got.actuation_changed !== want.actuation_changed) begin
        $error("actuation_changed: expected %0b, got %0b", want.actuation_changed,
               got.actuation_changed);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_override_request = 1'b0;
  logic                    in_card_present = 1'b0;
  logic [UID_W-1:0]        in_card_uid = '0;
  logic                    in_door_switch_open = 1'b0;
  logic [ADC_BITS_DEF-1:0] in_tilt_inside_sample = '0;
  logic [ADC_BITS_DEF-1:0] in_tilt_outside_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_solenoid_drive;
  logic                    out_door_unlocked;
  logic [1:0]              out_sound_event;
  logic                    out_actuation_changed;

  lock_scoreboard sb;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  switch_level = 1'b0;

  door_lock_access_controller_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_override_request    (in_override_request),
    .in_card_present        (in_card_present),
    .in_card_uid            (in_card_uid),
    .in_door_switch_open    (in_door_switch_open),
    .in_tilt_inside_sample  (in_tilt_inside_sample),
    .in_tilt_outside_sample (in_tilt_outside_sample),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_solenoid_drive     (out_solenoid_drive),
    .out_door_unlocked      (out_door_unlocked),
    .out_sound_event        (out_sound_event),
    .out_actuation_changed  (out_actuation_changed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.solenoid_drive    = out_solenoid_drive;
      got.door_unlocked     = out_door_unlocked;
      got.sound_event       = sound_t'(out_sound_event);
      got.actuation_changed = out_actuation_changed;
      sb.check_outcome(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCH_LIMIT);
      $display("FAIL door_lock_access_controller_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t mk_tick(bit ovr, bit card, logic [UID_W-1:0] uid, bit sw,
                                    logic [ADC_BITS_DEF-1:0] ti, logic [ADC_BITS_DEF-1:0] to);
    tick_t t;
    t.override_request = ovr;
    t.card_present     = card;
    t.card_uid         = uid;
    t.door_switch_open = sw;
    t.tilt_inside      = ti;
    t.tilt_outside     = to;
    return t;
  endfunction

  // Mostly small angles so the knob stays idle, with full-range samples mixed in.
  function automatic logic [ADC_BITS_DEF-1:0] pick_tilt();
    if ($urandom_range(99) < 60) return ADC_BITS_DEF'($urandom_range(0, 100));
    return ADC_BITS_DEF'($urandom_range(0, ADC_FULL));
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    pick;
    t.override_request = ($urandom_range(99) < 5);
    t.card_present     = ($urandom_range(99) < 30);
    pick = $urandom_range(9);
    if (pick < 5) t.card_uid = sb.uid_accepted;
    else if (pick < 7) t.card_uid = sb.uid_accepted ^ (32'd1 << $urandom_range(31));
    else t.card_uid = $urandom;
    if ($urandom_range(99) < 12) switch_level = !switch_level;
    t.door_switch_open = switch_level;
    t.tilt_inside      = pick_tilt();
    t.tilt_outside     = pick_tilt();
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid               <= 1'b1;
    in_override_request    <= t.override_request;
    in_card_present        <= t.card_present;
    in_card_uid            <= t.card_uid;
    in_door_switch_open    <= t.door_switch_open;
    in_tilt_inside_sample  <= t.tilt_inside;
    in_tilt_outside_sample <= t.tilt_outside;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_tick(t);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits for every outstanding result, then lets the pipeline empty.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [TIME_W-1:0] open_t, input logic [TIME_W-1:0] scan,
                                input logic [TIME_W-1:0] warn, input logic [TIME_W-1:0] act,
                                input logic [UID_W-1:0] uid, input logic [ANGLE_W-1:0] lo,
                                input logic [ANGLE_W-1:0] hi);
    write_reg(REG_OPEN_TIME, CFG_DATA_W'(open_t));
    write_reg(REG_CARD_GAP, CFG_DATA_W'(scan));
    write_reg(REG_WARN_DELAY, CFG_DATA_W'(warn));
    write_reg(REG_ACTUATE_TIME, CFG_DATA_W'(act));
    write_reg(REG_VALID_UID, uid);
    write_reg(REG_TILT_LOW, CFG_DATA_W'(lo));
    write_reg(REG_TILT_HIGH, CFG_DATA_W'(hi));
  endtask

  initial begin
    int               ph, n;
    tick_t            t;
    logic [ANGLE_W-1:0] lo, hi;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks with short timers so every branch shows up quickly.
    apply_settings(2, 1, 1, 1, VALID_UID_RST, TILT_LOW_RST, TILT_HIGH_RST);
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    send_tick(mk_tick(0, 1, VALID_UID_RST, 0, 0, 0));
    send_tick(mk_tick(1, 0, 32'h0, 1, 0, 0));
    send_tick(mk_tick(0, 1, 32'hFFFF_FFFF, 1, ADC_BITS_DEF'(ADC_FULL),
                      ADC_BITS_DEF'(ADC_FULL)));
    send_tick(mk_tick(0, 0, 32'h0, 1, 0, 0));
    send_tick(mk_tick(0, 0, 32'h0, 1, 0, 0));
    send_tick(mk_tick(0, 0, 32'h0, 1, 0, 0));
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    send_tick(mk_tick(0, 1, 32'h0, 0, 0, 0));
    send_tick(mk_tick(0, 1, VALID_UID_RST, 0, 0, 0));
    send_tick(mk_tick(0, 0, VALID_UID_RST, 0, 0, 0));
    // Samples straddling both edges of the turned window.
    send_tick(mk_tick(0, 0, 32'h0, 0, 359, 0));
    send_tick(mk_tick(0, 0, 32'h0, 0, 360, 0));
    send_tick(mk_tick(0, 0, 32'h0, 0, ADC_BITS_DEF'(ADC_FULL), 1448));
    send_tick(mk_tick(0, 0, 32'h0, 0, 1449, 1449));
    send_tick(mk_tick(0, 0, 32'h0, 0, 1449, 1449));
    send_tick(mk_tick(0, 0, 32'h0, 0, 1449, 1449));
    send_tick(mk_tick(0, 0, 32'h0, 0, 1449, 1449));
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 359));
    send_tick(mk_tick(1, 1, VALID_UID_RST, 0, 360, 360));
    stop_sending();
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      lo = ANGLE_W'($urandom_range(0, 200));
      hi = lo + ANGLE_W'($urandom_range(0, 142));
      if (ph == 9) begin
        // Inverted window: no sample may count as a turned knob.
        lo = ANGLE_W'(200 + $urandom_range(1, 142));
        hi = ANGLE_W'($urandom_range(0, 200));
      end
      case (ph)
        1: apply_settings(0, 0, 0, 0, 32'h0000_0000, 0, ANGLE_FULL);
        6: apply_settings(40, 25, 30, 20, 32'hFFFF_FFFF, ANGLE_FULL, ANGLE_FULL);
        default: apply_settings(TIME_W'($urandom_range(0, 30)), TIME_W'($urandom_range(0, 20)),
                                TIME_W'($urandom_range(0, 20)), TIME_W'($urandom_range(0, 15)),
                                $urandom, lo, hi);
      endcase
      for (n = 0; n < PHASE_TICKS; n++) begin
        if (ph == 4 && n == 30) hold_req = 1'b1;
        if (ph == 5 && n == 50) begin
          stop_sending();
          while (sb.pending() != 0) @(posedge clk);
        end
        send_tick(rand_tick());
      end
      stop_sending();
      drain();
    end

    // Thresholds at the top of the range: with the door locked nothing may fire.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sb.door_open) send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    stop_sending();
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom, ANGLE_FULL, 9'd0);
    for (n = 0; n < 60; n++) begin
      t = rand_tick();
      t.override_request = 1'b0;
      t.card_present     = 1'($urandom_range(1));
      send_tick(t);
    end
    send_tick(mk_tick(1, 0, 32'h0, 1, 0, 0));
    stop_sending();
    drain();
    // Door held open with the switch open: no relock and no warning yet.
    write_reg(REG_OPEN_TIME, 32'h0000_FFFE);
    for (n = 0; n < 20; n++) begin
      t = rand_tick();
      t.override_request = 1'b0;
      t.door_switch_open = 1'b1;
      send_tick(t);
    end
    send_tick(mk_tick(0, 0, 32'h0, 0, 0, 0));
    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d ticks: directed cases, %0d random setting phases under stalls,",
             sb.ticks, PHASES);
    $display("and top-of-range thresholds; %0d grants, %0d denials, %0d warnings, %0d actuations.",
             sb.grants, sb.denials, sb.warnings, sb.actuations);
    if (sb.errors == 0) begin
      $display("PASS door_lock_access_controller_top");
    end else begin
      $display("FAIL door_lock_access_controller_top");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/dlac_pkg.sv
rtl/core/dlac_cfg_regs.sv
rtl/core/dlac_tilt.sv
rtl/core/dlac_ctrl.sv
rtl/core/door_lock_access_controller_top.sv
bench/tb_door_lock_access_controller_top.sv
